// ===== hdl/plfr_pkg.sv =====
package plfr_pkg;

	localparam int SIDE = 5;
	localparam int LETTER_W = 5;
	localparam int SQUARE_W = SIDE * SIDE * LETTER_W;
	localparam int CFG_W = 50;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [SQUARE_W-1:0] square_t;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t PAD_RESET = 5'd23;

	typedef enum logic [2:0] {
		REG_SQUARE_LOW   = 3'd0,
		REG_SQUARE_MID   = 3'd1,
		REG_SQUARE_HIGH  = 3'd2,
		REG_DECRYPT_MODE = 3'd3,
		REG_PAD_LETTER   = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] row;
		logic [2:0] col;
	} loc_t;

	// 25 parallel compares, highest entry wins
	function automatic loc_t scan(square_t sq, letter_t l);
		loc_t r;
		r = '0;
		for (int row = 0; row < SIDE; row++) begin
			for (int col = 0; col < SIDE; col++) begin
				if (sq[(row*SIDE+col)*LETTER_W +: LETTER_W] == l) begin
					r.hit = 1'b1;
					r.row = 3'(row);
					r.col = 3'(col);
				end
			end
		end
		return r;
	endfunction

	// missing letters count as I, and as entry 0 when I is missing too
	function automatic loc_t locate(square_t sq, letter_t l, loc_t loc_i);
		loc_t s;
		s = scan(sq, l);
		if (s.hit) begin
			return s;
		end else if (loc_i.hit) begin
			return loc_i;
		end
		return '0;
	endfunction

	function automatic letter_t cell_at(square_t sq, logic [2:0] row, logic [2:0] col);
		logic [4:0] e;
		logic [6:0] base;
		e = {row, 2'b00} + 5'(row) + 5'(col);
		base = 7'(e) * 7'd5;
		return sq[base +: LETTER_W];
	endfunction

	function automatic logic [2:0] wrap_step(logic [2:0] v, logic dec);
		if (dec) begin
			return (v == 3'd0) ? 3'd4 : v - 3'd1;
		end
		return (v == 3'd4) ? 3'd0 : v + 3'd1;
	endfunction

	// returns {first, second}
	function automatic logic [2*LETTER_W-1:0] pair_rule(square_t sq, loc_t pa, loc_t pb,
			logic dec);
		letter_t oa;
		letter_t ob;
		if (pa.row == pb.row) begin
			oa = cell_at(sq, pa.row, wrap_step(pa.col, dec));
			ob = cell_at(sq, pb.row, wrap_step(pb.col, dec));
		end else if (pa.col == pb.col) begin
			oa = cell_at(sq, wrap_step(pa.row, dec), pa.col);
			ob = cell_at(sq, wrap_step(pb.row, dec), pb.col);
		end else begin
			oa = cell_at(sq, pa.row, pb.col);
			ob = cell_at(sq, pb.row, pa.col);
		end
		return {oa, ob};
	endfunction

endpackage

// ===== hdl/playfair_digraph_cipher.sv =====
// an item passes through the input register and then the result buffer; the input
// register holds its item while the result buffer is busy, and the block can take a new
// item while the result buffer drains the last one. The output gives one result letter per
// cycle while out_ready is high; an item produces 0 to 4 letters (2 for a typical pair)
// reset: asynchronous, active low; clears the key square, mode, held letter and
// all valid state, and loads the pad letter with X
module playfair_digraph_cipher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_en,
	input  logic [2:0]             cfg_index,
	input  logic [plfr_pkg::CFG_W-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [4:0]             letter_in,
	input  logic                   message_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [4:0]             letter_out,
	output logic                   run_last,
	output logic                   message_done
);
	import plfr_pkg::*;

	// configuration
	logic [49:0] sq_low_q;
	logic [49:0] sq_mid_q;
	logic [24:0] sq_high_q;
	logic        dec_q;
	letter_t     pad_q;
	square_t     sq;

	// first letter of an open pair
	letter_t held_q;
	logic    held_v_q;

	// input register
	logic    v_s1;
	logic    p0_s1;
	logic    p1_s1;
	logic    dec_s1;
	logic    end_s1;
	letter_t pad_s1;
	letter_t a0_s1;
	letter_t b0_s1;
	letter_t a1_s1;
	letter_t b1_s1;

	// result buffer
	letter_t    res_q [4];
	logic [2:0] cnt_q;
	logic [1:0] pos_q;
	logic       end_q;

	// next-state of the pairing logic
	letter_t lin;
	letter_t held_n;
	logic    hv_n;
	logic    p0_n;
	logic    p1_n;
	letter_t a0_n;
	letter_t b0_n;
	letter_t a1_n;
	letter_t b1_n;

	// rule evaluation
	loc_t                  loc_i;
	loc_t                  l0a;
	loc_t                  l0b;
	loc_t                  l1a;
	loc_t                  l1b;
	logic [2*LETTER_W-1:0] r0;
	logic [2*LETTER_W-1:0] r1;
	logic [2:0]            n_res;

	logic in_go;
	logic out_go;
	logic last;
	logic buf_free;
	logic s1_go;

	assign sq = {sq_high_q, sq_mid_q, sq_low_q};

	assign out_valid = (cnt_q != 3'd0);
	assign last = ({1'b0, pos_q} == (cnt_q - 3'd1));
	assign out_go = out_valid && out_ready;
	assign buf_free = (cnt_q == 3'd0) || (out_go && last);
	assign s1_go = v_s1 && buf_free;
	assign in_ready = !v_s1 || buf_free;
	assign in_go = in_valid && in_ready;

	assign letter_out = res_q[pos_q];
	assign run_last = last;
	assign message_done = last && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_low_q <= '0;
			sq_mid_q <= '0;
			sq_high_q <= '0;
			dec_q <= 1'b0;
			pad_q <= PAD_RESET;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_SQUARE_LOW:   sq_low_q <= cfg_data[49:0];
				REG_SQUARE_MID:   sq_mid_q <= cfg_data[49:0];
				REG_SQUARE_HIGH:  sq_high_q <= cfg_data[24:0];
				REG_DECRYPT_MODE: dec_q <= cfg_data[0];
				REG_PAD_LETTER:   pad_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// pairing: decides which pairs this letter closes and what stays held
	always_comb begin
		lin = (!dec_q && letter_in == LETTER_J) ? LETTER_I : letter_in;
		held_n = held_q;
		hv_n = held_v_q;
		p0_n = 1'b0;
		p1_n = 1'b0;
		a0_n = held_q;
		b0_n = lin;
		a1_n = lin;
		b1_n = pad_q;
		if (!dec_q) begin
			if (held_v_q) begin
				p0_n = 1'b1;
				if (held_q == lin) begin
					// doubled letter: pad the held one, keep the new one
					b0_n = pad_q;
					held_n = lin;
					p1_n = message_end;
				end else begin
					hv_n = 1'b0;
				end
			end else begin
				held_n = lin;
				hv_n = 1'b1;
				if (message_end) begin
					p0_n = 1'b1;
					a0_n = lin;
					b0_n = pad_q;
				end
			end
		end else begin
			if (held_v_q) begin
				p0_n = 1'b1;
				hv_n = 1'b0;
			end else if (!message_end) begin
				held_n = lin;
				hv_n = 1'b1;
			end
		end
		if (message_end) begin
			hv_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			held_v_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (in_go) begin
				held_q <= held_n;
				held_v_q <= hv_n;
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			p0_s1 <= p0_n;
			p1_s1 <= p1_n;
			dec_s1 <= dec_q;
			end_s1 <= message_end;
			pad_s1 <= pad_q;
			a0_s1 <= a0_n;
			b0_s1 <= b0_n;
			a1_s1 <= a1_n;
			b1_s1 <= b1_n;
		end
	end

	always_comb begin
		loc_i = scan(sq, LETTER_I);
		l0a = locate(sq, a0_s1, loc_i);
		l0b = locate(sq, b0_s1, loc_i);
		l1a = locate(sq, a1_s1, loc_i);
		l1b = locate(sq, b1_s1, loc_i);
		r0 = pair_rule(sq, l0a, l0b, dec_s1);
		r1 = pair_rule(sq, l1a, l1b, dec_s1);
		if (!p0_s1) begin
			n_res = 3'd0;
		end else if (dec_s1) begin
			// a decoded second letter equal to the pad is dropped
			n_res = (r0[LETTER_W-1:0] != pad_s1) ? 3'd2 : 3'd1;
		end else begin
			n_res = p1_s1 ? 3'd4 : 3'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
		end else if (s1_go) begin
			cnt_q <= n_res;
			pos_q <= '0;
		end else if (out_go) begin
			if (last) begin
				cnt_q <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_q[0] <= r0[2*LETTER_W-1:LETTER_W];
			res_q[1] <= r0[LETTER_W-1:0];
			res_q[2] <= r1[2*LETTER_W-1:LETTER_W];
			res_q[3] <= r1[LETTER_W-1:0];
			end_q <= end_s1;
		end
	end

endmodule

// ===== hdl/plfr_chk.sv =====
module plfr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] letter_out,
	input logic       run_last,
	input logic       message_done
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(letter_out) && $stable(run_last)
			&& $stable(message_done))
		else $error("result changed while stalled");

	a_done_last: assert property (@(posedge clk)
		out_valid && message_done |-> run_last)
		else $error("message_done without run_last");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	// a run continues until its last letter is transferred
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("run broken before its last letter");

	// input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind playfair_digraph_cipher plfr_chk u_plfr_chk (.*);

// ===== sim/playfair_digraph_cipher_monitor.sv =====
`timescale 1ns / 100ps

module playfair_digraph_cipher_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_en,
	input  logic [2:0]                 cfg_index,
	input  logic [plfr_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [4:0]                 letter_in,
	input  logic                       message_end,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [4:0]                 letter_out,
	input  logic                       run_last,
	input  logic                       message_done,
	output int                         fail_count,
	output int                         waiting,
	output int                         letters_checked
);
	import plfr_pkg::*;

	typedef struct packed {
		letter_t letter;
		logic    last;
		logic    done;
	} cipher_letter_t;

	cipher_letter_t pending_letters[$];

	square_t square;
	logic    decrypting;
	letter_t pad;
	letter_t held;
	logic    holding;

	function automatic letter_t entry(input int e);
		return square[e*LETTER_W +: LETTER_W];
	endfunction

	// last hit wins; absent letters fall back to I, then to entry 0
	function automatic int find_entry(input letter_t l);
		int pos;
		pos = -1;
		for (int e = 0; e < SIDE*SIDE; e++) begin
			if (entry(e) == l) pos = e;
		end
		if (pos < 0) begin
			for (int e = 0; e < SIDE*SIDE; e++) begin
				if (entry(e) == LETTER_I) pos = e;
			end
		end
		return (pos < 0) ? 0 : pos;
	endfunction

	function automatic void digraph(input letter_t a, input letter_t b, input logic back,
			output letter_t oa, output letter_t ob);
		int pa, pb, ra, ca, rb, cb, shift;
		pa = find_entry(a);
		pb = find_entry(b);
		shift = back ? SIDE - 1 : 1;
		ra = pa / SIDE;
		ca = pa % SIDE;
		rb = pb / SIDE;
		cb = pb % SIDE;
		if (ra == rb) begin
			oa = entry(ra*SIDE + (ca + shift) % SIDE);
			ob = entry(rb*SIDE + (cb + shift) % SIDE);
		end else if (ca == cb) begin
			oa = entry(((ra + shift) % SIDE)*SIDE + ca);
			ob = entry(((rb + shift) % SIDE)*SIDE + cb);
		end else begin
			oa = entry(ra*SIDE + cb);
			ob = entry(rb*SIDE + ca);
		end
	endfunction

	function automatic void advance_cipher(input letter_t raw, input logic fin);
		letter_t outs[4];
		letter_t c, x, y;
		int n;
		n = 0;
		c = raw;
		if (!decrypting) begin
			if (c == LETTER_J) c = LETTER_I;
			if (holding) begin
				// a doubled letter is split by the pad and stays held
				if (held == c) begin
					digraph(held, pad, 1'b0, x, y);
				end else begin
					digraph(held, c, 1'b0, x, y);
					holding = 1'b0;
				end
				outs[0] = x;
				outs[1] = y;
				n = 2;
			end else begin
				held = c;
				holding = 1'b1;
			end
			if (fin && holding) begin
				digraph(held, pad, 1'b0, x, y);
				outs[n] = x;
				outs[n+1] = y;
				n += 2;
				holding = 1'b0;
			end
		end else begin
			if (holding) begin
				digraph(held, c, 1'b1, x, y);
				outs[0] = x;
				n = 1;
				if (y != pad) begin
					outs[1] = y;
					n = 2;
				end
				holding = 1'b0;
			end else if (!fin) begin
				held = c;
				holding = 1'b1;
			end
		end
		if (fin) holding = 1'b0;
		for (int k = 0; k < n; k++) begin
			pending_letters.push_back('{letter: outs[k], last: (k == n - 1),
				done: (k == n - 1) && fin});
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		cipher_letter_t want;
		if (!arst_n) begin
			square = '0;
			decrypting = 1'b0;
			pad = PAD_RESET;
			held = '0;
			holding = 1'b0;
			pending_letters.delete();
			fail_count = 0;
			letters_checked = 0;
			waiting <= 0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
				REG_SQUARE_LOW:   square[CFG_W-1:0] = cfg_data;
				REG_SQUARE_MID:   square[2*CFG_W-1:CFG_W] = cfg_data;
				REG_SQUARE_HIGH:  square[SQUARE_W-1:2*CFG_W] = cfg_data[SQUARE_W-2*CFG_W-1:0];
				REG_DECRYPT_MODE: decrypting = cfg_data[0];
				REG_PAD_LETTER:   pad = cfg_data[LETTER_W-1:0];
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_letters.size() == 0) begin
					report_mismatch("letter with nothing pending", letter_out, -1);
				end else begin
					want = pending_letters.pop_front();
					letters_checked++;
					if (letter_out !== want.letter)
						report_mismatch("letter_out", letter_out, want.letter);
					if (run_last !== want.last)
						report_mismatch("run_last", run_last, want.last);
					if (message_done !== want.done)
						report_mismatch("message_done", message_done, want.done);
				end
			end
			if (in_valid && in_ready) advance_cipher(letter_in, message_end);
			waiting <= pending_letters.size();
		end
	end

endmodule

// ===== sim/playfair_digraph_cipher_tb.sv =====
`timescale 1ns / 100ps

module playfair_digraph_cipher_tb;
	import plfr_pkg::*;

	localparam int KEY_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 55;
	localparam int LONG_HOLD = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 10;

	logic             clk;
	logic             arst_n;
	logic             cfg_en;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [4:0]       letter_in;
	logic             message_end;
	logic             out_valid;
	logic             out_ready;
	logic [4:0]       letter_out;
	logic             run_last;
	logic             message_done;

	int fail_count;
	int waiting;
	int letters_checked;
	int letters_sent = 0;
	int messages_sent = 0;
	int settings_used = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int hold_requests = 0;

	playfair_digraph_cipher uut (.*);

	playfair_digraph_cipher_monitor cipher_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// no transfer on either channel for too long means the block hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// output side: ready level is redrawn at the end of each random span, plus one long hold
	initial begin : receiver
		int hold_left, level, span, holds_started;
		hold_left = 0;
		level = 8;
		span = 0;
		holds_started = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_started) begin
				holds_started = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (span == 0) begin
				span = $urandom_range(16, 80);
				case ($urandom_range(0, 3))
				0: level = 8;
				1: level = 6;
				2: level = 3;
				default: level = 1;
				endcase
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 7) < level);
			end
		end
	end

	function automatic square_t pack_keyword(input string kw);
		square_t sq;
		sq = '0;
		for (int e = 0; e < SIDE*SIDE; e++) sq[e*LETTER_W +: LETTER_W] = letter_t'(kw[e] - "A");
		return sq;
	endfunction

	// 25 of the 26 letters in random order, so one letter is always missing
	function automatic square_t shuffled_square();
		letter_t pool[26];
		letter_t t;
		int j;
		square_t sq;
		for (int k = 0; k < 26; k++) pool[k] = letter_t'(k);
		for (int k = 25; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = pool[k];
			pool[k] = pool[j];
			pool[j] = t;
		end
		for (int e = 0; e < SIDE*SIDE; e++) sq[e*LETTER_W +: LETTER_W] = pool[e];
		return sq;
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_square(input square_t key);
		write_reg(REG_SQUARE_LOW, key[CFG_W-1:0]);
		write_reg(REG_SQUARE_MID, key[2*CFG_W-1:CFG_W]);
		write_reg(REG_SQUARE_HIGH, CFG_W'(key[SQUARE_W-1:2*CFG_W]));
	endtask

	task automatic load_setting(input square_t key, input logic dec, input letter_t pad);
		load_square(key);
		write_reg(REG_DECRYPT_MODE, CFG_W'(dec));
		write_reg(REG_PAD_LETTER, CFG_W'(pad));
		cfg_en <= 1'b0;
		settings_used++;
	endtask

	// valid stays up through a burst; a gap follows when the burst runs out
	task automatic send_letter(input letter_t l, input logic fin);
		in_valid <= 1'b1;
		letter_in <= l;
		message_end <= fin;
		do @(posedge clk); while (!in_ready);
		letters_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_text(input string letters, input string ends);
		for (int k = 0; k < letters.len(); k++)
			send_letter(letter_t'(letters[k] - "A"), ends[k] == "1");
	endtask

	// mostly letters taken from the square, some repeats to force pad splits,
	// and now and then a message left open so pairs straddle messages
	task automatic send_message(input square_t key);
		int len, idx;
		letter_t l, prev, pick;
		logic closed;
		len = $urandom_range(1, 10);
		closed = ($urandom_range(0, 9) != 0);
		prev = '0;
		for (int k = 0; k < len; k++) begin
			idx = $urandom_range(0, SIDE*SIDE - 1);
			pick = key[idx*LETTER_W +: LETTER_W];
			if (k > 0 && $urandom_range(0, 4) == 0) l = prev;
			else if (pick <= 5'd25 && $urandom_range(0, 2) != 0) l = pick;
			else l = letter_t'($urandom_range(0, 25));
			send_letter(l, closed && (k == len - 1));
			prev = l;
		end
		messages_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		square_t key;
		letter_t pad;
		int target;
		arst_n <= 1'b0;
		cfg_en <= 1'b0;
		cfg_index <= REG_SQUARE_LOW;
		cfg_data <= '0;
		in_valid <= 1'b0;
		letter_in <= '0;
		message_end <= 1'b0;
		burst_left = $urandom_range(0, 24);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// textbook square; mode and pad stay at their reset values
		load_square(pack_keyword("PLAYFIREXMBCDGHKNOQSTUVWZ"));
		cfg_en <= 1'b0;
		settings_used++;
		// rectangle, J folding with a doubled pair at message end, odd final letter,
		// column and row wrap, pad pair, then B left held across the mode change
		send_text("HIJIZSZWZXXMB", "0001100010010");
		wait_idle();
		write_reg(REG_DECRYPT_MODE, CFG_W'(1'b1));
		cfg_en <= 1'b0;
		// held B pairs under decryption, pad drop, J missing from square,
		// dangling odd letter, column, rectangle at the code extremes
		send_text("CRMJEQKTAZ", "0000010001");
		wait_idle();

		for (int p = 0; p < KEY_SETTINGS; p++) begin
			case (p)
			2, 6: key = SQUARE_W'({$urandom, $urandom, $urandom, $urandom});
			4: key = '1;
			5: key = '0;
			default: key = shuffled_square();
			endcase
			case (p)
			0: pad = PAD_RESET;
			2, 5: pad = 5'd0;
			3, 4: pad = 5'd25;
			default: pad = letter_t'($urandom_range(0, 25));
			endcase
			load_setting(key, p[0], pad);
			if (p == 1) hold_requests++;
			target = letters_sent + ITEMS_PER_SETTING;
			while (letters_sent < target) send_message(key);
			wait_idle();
		end

		$display("covered %0d input letters, %0d random messages, %0d key settings",
			letters_sent, messages_sent, settings_used);
		$display("%0d output letters checked over both modes and a long output hold",
			letters_checked);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
